// ===== rtl/lfrs_pkg.sv =====
// Package for the line follower route sequencer.
// Holds motor command codes, phase codes, leg codes and the result type.
// No dependencies.
package lfrs_pkg;

  localparam int TICK_BITS_DEF = 10;
  localparam int CFG_W         = 10;
  localparam int CMD_W         = 3;
  localparam int PHASE_W       = 4;

  localparam logic [CFG_W-1:0] TURN_LEAD_RESET = 10'd100;
  localparam logic [CFG_W-1:0] REVERSE_RESET   = 10'd50;

  localparam logic CFG_TURN_LEAD = 1'b0;
  localparam logic CFG_REVERSE   = 1'b1;

  localparam logic [CMD_W-1:0] CMD_STOP  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FWD   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_LEFT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RIGHT = 3'd3;
  localparam logic [CMD_W-1:0] CMD_BACK  = 3'd4;

  localparam logic [1:0] LEG_RIGHT    = 2'd1;
  localparam logic [1:0] LEG_STRAIGHT = 2'd2;
  localparam logic [1:0] LEG_LEFT     = 2'd3;

  localparam logic [PHASE_W-1:0] PH_IDLE   = 4'd0;
  localparam logic [PHASE_W-1:0] PH_SEEK1  = 4'd1;
  localparam logic [PHASE_W-1:0] PH_CROSS1 = 4'd2;
  localparam logic [PHASE_W-1:0] PH_LEAD   = 4'd3;
  localparam logic [PHASE_W-1:0] PH_SPIN0  = 4'd4;
  localparam logic [PHASE_W-1:0] PH_SPIN1  = 4'd5;
  localparam logic [PHASE_W-1:0] PH_SPIN2  = 4'd6;
  localparam logic [PHASE_W-1:0] PH_SPIN3  = 4'd7;
  localparam logic [PHASE_W-1:0] PH_SEEK2  = 4'd8;
  localparam logic [PHASE_W-1:0] PH_CROSS2 = 4'd9;
  localparam logic [PHASE_W-1:0] PH_BACK   = 4'd10;
  localparam logic [PHASE_W-1:0] PH_FSPIN0 = 4'd11;
  localparam logic [PHASE_W-1:0] PH_FSPIN1 = 4'd12;
  localparam logic [PHASE_W-1:0] PH_FSPIN2 = 4'd13;
  localparam logic [PHASE_W-1:0] PH_FSPIN3 = 4'd14;

  typedef struct packed {
    logic [CMD_W-1:0] motor_cmd;
    logic [1:0]       station;
    logic             busy_res;
  } res_t;

  function automatic logic [CMD_W-1:0] track_cmd(input logic l, input logic r);
    if (l == r) begin
      return CMD_FWD;
    end
    return l ? CMD_LEFT : CMD_RIGHT;
  endfunction

  function automatic logic spin_done(input logic [1:0] step, input logic right_spin,
                                     input logic l, input logic r);
    logic first;
    logic second;
    logic s;
    first  = right_spin ? l : r;
    second = right_spin ? r : l;
    s      = step[1] ? second : first;
    return s == ~step[0];
  endfunction

endpackage

// ===== rtl/line_follower_route_sequencer.sv =====
// Line follower route sequencer: top level, phase sequencer and output skid stage.
// Depends on lfrs_pkg.
// The two-entry output stage (out_r, skid_r) registers each accepted result.
// Throughput: one transaction per cycle unless in_stall; skid entry absorbs stalls.
// Reset (rst_n low, synchronous): idle at station A, registers back to 100 and 50.
module line_follower_route_sequencer
  import lfrs_pkg::*;
#(
  parameter int TICK_BITS = TICK_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_left_sensor,
  input  logic              in_right_sensor,
  input  logic              in_tick,
  input  logic              in_request,
  input  logic [1:0]        in_destination,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CMD_W-1:0]  out_motor_cmd,
  output logic [1:0]        out_station,
  output logic              out_busy_res
);

  logic [CFG_W-1:0]     turn_lead_r;
  logic [CFG_W-1:0]     reverse_r;
  logic [PHASE_W-1:0]   phase_r, phase_nxt;
  logic [1:0]           station_r, station_nxt;
  logic [1:0]           target_r, target_nxt;
  logic [1:0]           leg_r, leg_nxt;
  logic [TICK_BITS-1:0] count_r, count_nxt;

  res_t res;
  res_t out_r;
  res_t skid_r;
  logic out_valid_r;
  logic skid_valid_r;
  logic accept;
  logic out_take;
  logic both;
  logic right_turn;
  logic [PHASE_W-1:0] spin_off;
  logic [PHASE_W-1:0] fspin_off;
  logic [CMD_W-1:0]   cmd;

  assign accept   = in_valid && !skid_valid_r;
  assign out_take = out_valid_r && !out_stall;
  assign in_stall = skid_valid_r;

  always_comb begin
    phase_nxt   = phase_r;
    station_nxt = station_r;
    target_nxt  = target_r;
    leg_nxt     = leg_r;
    count_nxt   = count_r;
    cmd         = CMD_STOP;
    both        = in_left_sensor && in_right_sensor;
    right_turn  = (leg_r == LEG_RIGHT);
    spin_off    = phase_r - PH_SPIN0;
    fspin_off   = phase_r - PH_FSPIN0;
    case (phase_r)
      PH_IDLE: begin
        if (in_request && in_destination != station_r) begin
          target_nxt = in_destination;
          leg_nxt    = in_destination - station_r;
          phase_nxt  = PH_SEEK1;
        end
      end
      PH_SEEK1, PH_SEEK2: begin
        cmd = track_cmd(in_left_sensor, in_right_sensor);
        if (both) begin
          phase_nxt = phase_r + PHASE_W'(1);
        end
      end
      PH_CROSS1: begin
        if (both) begin
          cmd = CMD_FWD;
        end else if (leg_r == LEG_RIGHT || leg_r == LEG_LEFT) begin
          count_nxt = TICK_BITS'(turn_lead_r);
          phase_nxt = PH_LEAD;
        end else begin
          phase_nxt = PH_SEEK2;
        end
      end
      PH_CROSS2: begin
        if (both) begin
          cmd = CMD_FWD;
        end else begin
          station_nxt = target_r;
          count_nxt   = TICK_BITS'(reverse_r);
          phase_nxt   = PH_BACK;
        end
      end
      PH_LEAD: begin
        if (count_r == '0) begin
          cmd       = right_turn ? CMD_RIGHT : CMD_LEFT;
          phase_nxt = PH_SPIN0;
        end else begin
          cmd = track_cmd(in_left_sensor, in_right_sensor);
          if (in_tick) begin
            count_nxt = count_r - TICK_BITS'(1);
          end
        end
      end
      PH_SPIN0, PH_SPIN1, PH_SPIN2, PH_SPIN3: begin
        cmd = right_turn ? CMD_RIGHT : CMD_LEFT;
        if (spin_done(spin_off[1:0], right_turn, in_left_sensor, in_right_sensor)) begin
          phase_nxt = (phase_r == PH_SPIN3) ? PH_SEEK2 : phase_r + PHASE_W'(1);
        end
      end
      PH_BACK: begin
        if (count_r == '0) begin
          cmd       = CMD_RIGHT;
          phase_nxt = PH_FSPIN0;
        end else begin
          cmd = CMD_BACK;
          if (in_tick) begin
            count_nxt = count_r - TICK_BITS'(1);
          end
        end
      end
      PH_FSPIN0, PH_FSPIN1, PH_FSPIN2, PH_FSPIN3: begin
        cmd = CMD_RIGHT;
        if (spin_done(fspin_off[1:0], 1'b1, in_left_sensor, in_right_sensor)) begin
          if (phase_r == PH_FSPIN3) begin
            cmd       = CMD_STOP;
            phase_nxt = PH_IDLE;
          end else begin
            phase_nxt = phase_r + PHASE_W'(1);
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
    res.motor_cmd = cmd;
    res.station   = station_nxt;
    res.busy_res  = (phase_nxt != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      turn_lead_r <= TURN_LEAD_RESET;
      reverse_r   <= REVERSE_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_TURN_LEAD) begin
        turn_lead_r <= cfg_data;
      end else begin
        reverse_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      station_r <= 2'd0;
      target_r  <= 2'd0;
      leg_r     <= 2'd0;
      count_r   <= '0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      station_r <= station_nxt;
      target_r  <= target_nxt;
      leg_r     <= leg_nxt;
      count_r   <= count_nxt;
    end
  end

  // hold the result while stalled; park a second transaction in the skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= accept;
      end
    end else if (accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_take) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (accept) begin
      skid_r <= res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_motor_cmd = out_r.motor_cmd;
  assign out_station   = out_r.station;
  assign out_busy_res  = out_r.busy_res;

endmodule

// ===== test/tb_line_follower_route_sequencer.sv =====
`timescale 1ns / 100ps
// Testbench for line_follower_route_sequencer: directed table, then steered random routes.
// Expected results come from the table or an in-bench route predictor; depends on lfrs_pkg and the RTL.
module tb_line_follower_route_sequencer;
  import lfrs_pkg::*;

  localparam int TICK_W     = TICK_BITS_DEF;
  localparam int QUIET_MAX  = 1000;
  localparam int N_PHASES   = 9;

  typedef struct packed {
    logic       lsen;
    logic       rsen;
    logic       tick;
    logic       req;
    logic [1:0] dest;
  } sample_t;

  typedef struct packed {
    logic             lsen;
    logic             rsen;
    logic             tick;
    logic             req;
    logic [1:0]       dest;
    logic             chk;
    logic [CMD_W-1:0] cmd;
    logic [1:0]       stn;
    logic             busy;
  } dir_row_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic             in_valid;
  logic             in_stall;
  logic             in_left_sensor;
  logic             in_right_sensor;
  logic             in_tick;
  logic             in_request;
  logic [1:0]       in_destination;
  logic             out_valid;
  logic             out_stall;
  logic [CMD_W-1:0] out_motor_cmd;
  logic [1:0]       out_station;
  logic             out_busy_res;

  logic [PHASE_W-1:0] rt_phase;
  logic [1:0]         rt_station;
  logic [1:0]         rt_target;
  logic [1:0]         rt_leg;
  logic [TICK_W-1:0]  rt_ticks;
  logic [CFG_W-1:0]   lead_reg;
  logic [CFG_W-1:0]   back_reg;

  res_t motion_q[$];
  res_t head;
  int   errors = 0;
  int   quiet_cycles = 0;
  bit   tight = 1'b0;

  // route with lead and reverse intervals of zero
  dir_row_t dir_tab [0:24] = '{
    '{1'b0, 1'b0, 1'b1, 1'b0, 2'd2, 1'b1, CMD_STOP,  2'd0, 1'b0},
    '{1'b1, 1'b1, 1'b0, 1'b1, 2'd0, 1'b1, CMD_STOP,  2'd0, 1'b0},
    '{1'b0, 1'b0, 1'b0, 1'b1, 2'd1, 1'b1, CMD_STOP,  2'd0, 1'b1},
    '{1'b1, 1'b0, 1'b1, 1'b1, 2'd3, 1'b1, CMD_LEFT,  2'd0, 1'b1},
    '{1'b0, 1'b1, 1'b0, 1'b0, 2'd0, 1'b1, CMD_RIGHT, 2'd0, 1'b1},
    '{1'b0, 1'b0, 1'b0, 1'b0, 2'd0, 1'b1, CMD_FWD,   2'd0, 1'b1},
    '{1'b1, 1'b1, 1'b0, 1'b0, 2'd0, 1'b1, CMD_FWD,   2'd0, 1'b1},
    '{1'b1, 1'b1, 1'b1, 1'b0, 2'd0, 1'b1, CMD_FWD,   2'd0, 1'b1},
    '{1'b0, 1'b0, 1'b0, 1'b0, 2'd0, 1'b1, CMD_STOP,  2'd0, 1'b1},
    '{1'b0, 1'b0, 1'b0, 1'b0, 2'd0, 1'b1, CMD_RIGHT, 2'd0, 1'b1},
    '{1'b1, 1'b0, 1'b0, 1'b0, 2'd0, 1'b1, CMD_RIGHT, 2'd0, 1'b1},
    '{1'b0, 1'b1, 1'b0, 1'b0, 2'd0, 1'b1, CMD_RIGHT, 2'd0, 1'b1},
    '{1'b0, 1'b1, 1'b0, 1'b0, 2'd0, 1'b1, CMD_RIGHT, 2'd0, 1'b1},
    '{1'b0, 1'b0, 1'b0, 1'b0, 2'd0, 1'b1, CMD_RIGHT, 2'd0, 1'b1},
    '{1'b1, 1'b1, 1'b0, 1'b0, 2'd0, 1'b1, CMD_FWD,   2'd0, 1'b1},
    '{1'b1, 1'b0, 1'b0, 1'b0, 2'd0, 1'b1, CMD_STOP,  2'd1, 1'b1},
    '{1'b0, 1'b0, 1'b0, 1'b0, 2'd0, 1'b1, CMD_RIGHT, 2'd1, 1'b1},
    '{1'b1, 1'b0, 1'b0, 1'b0, 2'd0, 1'b1, CMD_RIGHT, 2'd1, 1'b1},
    '{1'b0, 1'b0, 1'b0, 1'b0, 2'd0, 1'b1, CMD_RIGHT, 2'd1, 1'b1},
    '{1'b0, 1'b1, 1'b0, 1'b0, 2'd0, 1'b1, CMD_RIGHT, 2'd1, 1'b1},
    '{1'b0, 1'b0, 1'b0, 1'b0, 2'd0, 1'b1, CMD_STOP,  2'd1, 1'b0},
    '{1'b0, 1'b0, 1'b0, 1'b1, 2'd0, 1'b1, CMD_STOP,  2'd1, 1'b1},
    '{1'b1, 1'b1, 1'b0, 1'b0, 2'd0, 1'b0, CMD_STOP,  2'd0, 1'b0},
    '{1'b0, 1'b1, 1'b0, 1'b0, 2'd0, 1'b0, CMD_STOP,  2'd0, 1'b0},
    '{1'b0, 1'b0, 1'b1, 1'b0, 2'd0, 1'b0, CMD_STOP,  2'd0, 1'b0}
  };

  line_follower_route_sequencer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_left_sensor  (in_left_sensor),
    .in_right_sensor (in_right_sensor),
    .in_tick         (in_tick),
    .in_request      (in_request),
    .in_destination  (in_destination),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_motor_cmd   (out_motor_cmd),
    .out_station     (out_station),
    .out_busy_res    (out_busy_res)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [CMD_W-1:0] steer_cmd(input logic lsen, input logic rsen);
    if (lsen == rsen) begin
      return CMD_FWD;
    end
    return lsen ? CMD_LEFT : CMD_RIGHT;
  endfunction

  function automatic logic spin_hit(input logic [1:0] step, input logic rspin,
                                    input logic lsen, input logic rsen);
    logic watched;
    watched = ((step[1] == 1'b0) == rspin) ? lsen : rsen;
    return watched == ~step[0];
  endfunction

  function automatic res_t route_step(input sample_t s);
    res_t             res;
    logic [CMD_W-1:0] cmd;
    logic             both;
    logic             rturn;
    cmd   = CMD_STOP;
    both  = s.lsen & s.rsen;
    rturn = (rt_leg == LEG_RIGHT);
    case (rt_phase)
      PH_IDLE: begin
        if (s.req && s.dest != rt_station) begin
          rt_target = s.dest;
          rt_leg    = s.dest - rt_station;
          rt_phase  = PH_SEEK1;
        end
      end
      PH_SEEK1, PH_SEEK2: begin
        cmd = steer_cmd(s.lsen, s.rsen);
        if (both) rt_phase = rt_phase + PHASE_W'(1);
      end
      PH_CROSS1: begin
        if (both) begin
          cmd = CMD_FWD;
        end else if (rt_leg == LEG_RIGHT || rt_leg == LEG_LEFT) begin
          rt_ticks = lead_reg[TICK_W-1:0];
          rt_phase = PH_LEAD;
        end else begin
          rt_phase = PH_SEEK2;
        end
      end
      PH_CROSS2: begin
        if (both) begin
          cmd = CMD_FWD;
        end else begin
          rt_station = rt_target;
          rt_ticks   = back_reg[TICK_W-1:0];
          rt_phase   = PH_BACK;
        end
      end
      PH_LEAD: begin
        if (rt_ticks == '0) begin
          cmd      = rturn ? CMD_RIGHT : CMD_LEFT;
          rt_phase = PH_SPIN0;
        end else begin
          cmd = steer_cmd(s.lsen, s.rsen);
          if (s.tick) rt_ticks = rt_ticks - TICK_W'(1);
        end
      end
      PH_SPIN0, PH_SPIN1, PH_SPIN2, PH_SPIN3: begin
        cmd = rturn ? CMD_RIGHT : CMD_LEFT;
        if (spin_hit(2'(rt_phase - PH_SPIN0), rturn, s.lsen, s.rsen)) begin
          rt_phase = (rt_phase == PH_SPIN3) ? PH_SEEK2 : rt_phase + PHASE_W'(1);
        end
      end
      PH_BACK: begin
        if (rt_ticks == '0) begin
          cmd      = CMD_RIGHT;
          rt_phase = PH_FSPIN0;
        end else begin
          cmd = CMD_BACK;
          if (s.tick) rt_ticks = rt_ticks - TICK_W'(1);
        end
      end
      PH_FSPIN0, PH_FSPIN1, PH_FSPIN2, PH_FSPIN3: begin
        cmd = CMD_RIGHT;
        if (spin_hit(2'(rt_phase - PH_FSPIN0), 1'b1, s.lsen, s.rsen)) begin
          if (rt_phase == PH_FSPIN3) begin
            cmd      = CMD_STOP;
            rt_phase = PH_IDLE;
          end else begin
            rt_phase = rt_phase + PHASE_W'(1);
          end
        end
      end
      default: rt_phase = PH_IDLE;
    endcase
    res.motor_cmd = cmd;
    res.station   = rt_station;
    res.busy_res  = (rt_phase != PH_IDLE);
    return res;
  endfunction

  // steer toward the next phase, or return a random sample
  function automatic sample_t pick_sample(input bit steer);
    sample_t    s;
    logic [1:0] step;
    logic       rspin;
    s = sample_t'($urandom);
    if (steer) begin
      case (rt_phase)
        PH_IDLE: begin
          s.req  = 1'b1;
          s.dest = rt_station + 2'($urandom_range(1, 3));
        end
        PH_SEEK1, PH_SEEK2: {s.lsen, s.rsen} = 2'b11;
        PH_CROSS1, PH_CROSS2: {s.lsen, s.rsen} = 2'($urandom_range(0, 2));
        PH_LEAD, PH_BACK: s.tick = 1'b1;
        PH_SPIN0, PH_SPIN1, PH_SPIN2, PH_SPIN3,
        PH_FSPIN0, PH_FSPIN1, PH_FSPIN2, PH_FSPIN3: begin
          if (rt_phase >= PH_FSPIN0) begin
            step  = 2'(rt_phase - PH_FSPIN0);
            rspin = 1'b1;
          end else begin
            step  = 2'(rt_phase - PH_SPIN0);
            rspin = (rt_leg == LEG_RIGHT);
          end
          if ((step[1] == 1'b0) == rspin) s.lsen = ~step[0];
          else s.rsen = ~step[0];
        end
        default: ;
      endcase
    end
    return s;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_sample(input sample_t s, input logic chk, input res_t typed);
    int   gap;
    res_t pred;
    gap = tight ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_left_sensor  <= s.lsen;
    in_right_sensor <= s.rsen;
    in_tick         <= s.tick;
    in_request      <= s.req;
    in_destination  <= s.dest;
    in_valid        <= 1'b1;
    do @(posedge clk); while (in_stall);
    pred = route_step(s);
    motion_q.push_back(chk ? typed : pred);
    @(negedge clk);
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    @(negedge clk);
    while (motion_q.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic finish_route();
    while (rt_phase != PH_IDLE) send_sample(pick_sample(1'b1), 1'b0, '0);
    quiesce();
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_TURN_LEAD) lead_reg = val;
    else back_reg = val;
    @(negedge clk);
  endtask

  initial begin
    out_stall = 1'b1;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      out_stall <= 1'b0;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(30, 80)) @(negedge clk);
      else repeat ($urandom_range(1, 8)) @(negedge clk);
      out_stall <= 1'b1;
      repeat (pick_gap()) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (motion_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result cmd %0d station %0d busy %0d", $time,
                 out_motor_cmd, out_station, out_busy_res);
      end else begin
        head = motion_q.pop_front();
        if (out_motor_cmd !== head.motor_cmd) begin
          errors++;
          $display("%0t: motor_cmd expected %0d got %0d", $time, head.motor_cmd, out_motor_cmd);
        end
        if (out_station !== head.station) begin
          errors++;
          $display("%0t: station expected %0d got %0d", $time, head.station, out_station);
        end
        if (out_busy_res !== head.busy_res) begin
          errors++;
          $display("%0t: busy_res expected %0d got %0d", $time, head.busy_res, out_busy_res);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_MAX) begin
        $display("simulation failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int lv;
    int rv;
    int n;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_TURN_LEAD;
    cfg_data        = '0;
    in_valid        = 1'b0;
    in_left_sensor  = 1'b0;
    in_right_sensor = 1'b0;
    in_tick         = 1'b0;
    in_request      = 1'b0;
    in_destination  = 2'd0;
    rt_phase        = PH_IDLE;
    rt_station      = 2'd0;
    rt_target       = 2'd0;
    rt_leg          = 2'd0;
    rt_ticks        = '0;
    lead_reg        = TURN_LEAD_RESET;
    back_reg        = REVERSE_RESET;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    write_reg(CFG_TURN_LEAD, '0);
    write_reg(CFG_REVERSE, '0);
    foreach (dir_tab[i]) begin
      send_sample({dir_tab[i].lsen, dir_tab[i].rsen, dir_tab[i].tick, dir_tab[i].req,
                   dir_tab[i].dest}, dir_tab[i].chk,
                  {dir_tab[i].cmd, dir_tab[i].stn, dir_tab[i].busy});
    end
    finish_route();

    for (int p = 0; p < N_PHASES; p++) begin
      n = 75;
      case (p)
        0: begin lv = 1;    rv = 1;    end
        1: begin lv = 100;  rv = 50;   end
        2: begin lv = 40;   rv = 25;   n = 60; end
        3: begin lv = 0;    rv = 7;    end
        4: begin lv = 5;    rv = 0;    end
        default: begin
          lv = $urandom_range(1, 12);
          rv = $urandom_range(1, 12);
        end
      endcase
      write_reg(CFG_TURN_LEAD, CFG_W'(lv));
      write_reg(CFG_REVERSE, CFG_W'(rv));
      tight = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < n; k++) begin
        send_sample(pick_sample($urandom_range(0, 99) < 75), 1'b0, '0);
        if ($urandom_range(0, 149) == 0) quiesce();
      end
      finish_route();
    end

    quiesce();
    repeat (10) @(negedge clk);
    if (motion_q.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, motion_q.size());
    end
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
